/* rtl/tgqg_pkg.sv */
// tgqg_pkg: shared types, constants and helper functions for the glyph quad generator
// no dependencies; imported by text_glyph_quad_generator_top
package tgqg_pkg;

	// fixed-point format of positions
	localparam int FRAC_BITS = 16;
	localparam int CFG_W     = 24;
	localparam int REF_SHIFT = CFG_W - FRAC_BITS;
	localparam int RND_HALF  = (REF_SHIFT > 0) ? (1 << (REF_SHIFT - 1)) : 0;
	localparam int ONE       = 1 << FRAC_BITS;

	// field widths
	localparam int PX_W    = 12;
	localparam int CNT_W   = 10;
	localparam int COLOR_W = 32;
	localparam int CODE_W  = 16;
	localparam int POS_W   = 20;
	localparam int TEX_W   = 17;
	localparam int CIDX_W  = 2;

	// glyph cell in pixels, doubled for the ndc scale
	localparam int GLYPH_W_PX = 15;
	localparam int GLYPH_H_PX = 42;
	localparam int GW_PX2     = 2 * GLYPH_W_PX;
	localparam int GH_PX2     = 2 * GLYPH_H_PX;

	// internal widths
	localparam int GW_W = CFG_W + 5 - REF_SHIFT;
	localparam int GH_W = CFG_W + 7 - REF_SHIFT;
	localparam int PR_W = PX_W + CFG_W + 1;
	localparam int RV_W = PR_W - REF_SHIFT;
	localparam int NG_W = CNT_W + GW_W;
	localparam int CW_A = (RV_W > NG_W) ? RV_W : NG_W;
	localparam int CW   = ((CW_A > GH_W) ? CW_A : GH_W) + 2;
	localparam int SW   = CW + 1;

	// register reset values and the glyph sizes that follow from them
	localparam int INV_W_RESET = 13107;
	localparam int INV_H_RESET = 23302;
	localparam logic [GW_W-1:0] GW_RESET = GW_W'((INV_W_RESET * GW_PX2 + RND_HALF) >> REF_SHIFT);
	localparam logic [GH_W-1:0] GH_RESET = GH_W'((INV_H_RESET * GH_PX2 + RND_HALF) >> REF_SHIFT);

	// register indexes
	localparam logic [CIDX_W-1:0] CFG_INV_W = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_INV_H = 2'd1;

	// item kinds
	localparam logic OP_BEGIN = 1'b0;
	localparam logic OP_CHAR  = 1'b1;

	// character codes
	localparam logic [CODE_W-1:0] CHAR_NEWLINE = 16'd10;
	localparam logic [CODE_W-1:0] CHAR_FIRST   = 16'd32;
	localparam logic [CODE_W-1:0] CHAR_LAST    = 16'd126;

	// texture atlas: glyph columns side by side
	localparam int ATLAS_GLYPHS = 95;
	localparam int TEX_COLS     = ATLAS_GLYPHS + 1;
	localparam int TIDX_W       = 7;
	localparam int TEX_ONE      = 1 << 16;

	// quad corners: vertex order lt, rt, lb, rt, rb, lb
	localparam int VERT_N = 6;
	localparam int VCNT_W = 3;
	localparam logic [VCNT_W-1:0] VERT_LAST = 3'd5;
	localparam logic [VERT_N-1:0] X_RIGHT   = 6'b011010;
	localparam logic [VERT_N-1:0] Y_BOTTOM  = 6'b110100;

	// saturation limits
	localparam logic signed [SW-1:0] SAT_HI = SW'((1 << (POS_W - 1)) - 1);
	localparam logic signed [SW-1:0] SAT_LO = SW'(-(1 << (POS_W - 1)));

	typedef struct packed {
		logic               op;
		logic [PX_W-1:0]    rect_left;
		logic [PX_W-1:0]    rect_top;
		logic [PX_W-1:0]    rect_right;
		logic [PX_W-1:0]    rect_bottom;
		logic               center_text;
		logic [CNT_W-1:0]   char_count;
		logic [COLOR_W-1:0] text_color;
		logic [CODE_W-1:0]  char_code;
	} in_item_t;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic [TEX_W-1:0]        tex_u;
		logic                    tex_v;
		logic [COLOR_W-1:0]      vertex_color;
		logic                    last_vertex;
	} out_item_t;

	typedef logic [TEX_COLS-1:0][TEX_W-1:0] tex_tab_t;

	// u of each glyph column, rounded half up
	function automatic tex_tab_t tex_tab_build();
		tex_tab_t tab;
		for (int i = 0; i < TEX_COLS; i++) begin
			tab[i] = TEX_W'((2 * i * TEX_ONE + ATLAS_GLYPHS) / (2 * ATLAS_GLYPHS));
		end
		return tab;
	endfunction

	localparam tex_tab_t TEX_TAB = tex_tab_build();

	// q.24 product to position fraction bits, round half up
	function automatic logic [RV_W-1:0] rnd_px(input logic [PR_W-1:0] v);
		logic [PR_W-1:0] sum;
		sum = v + PR_W'(RND_HALF);
		return sum[PR_W-1:REF_SHIFT];
	endfunction

	// clamp to the signed position range
	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI;
		end else if (v < SAT_LO) begin
			r = SAT_LO;
		end else begin
			r = v;
		end
		return r[POS_W-1:0];
	endfunction

endpackage

/* rtl/text_glyph_quad_generator_top.sv */
// text_glyph_quad_generator_top: three-stage item pipeline feeding a quad vertex sequencer
// depends on tgqg_pkg
// the first vertex of a printable character is offered once it has passed stages 1 to 3
// and loaded the quad registers; the vertex sequencer sends it as six vertices and must finish
// before stage 3 loads the next; begin, newline and skipped items flow past a pending quad
// reset: arst_n clears pen, colour, valids and sequencer; registers take reset values
module text_glyph_quad_generator_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tgqg_pkg::CIDX_W-1:0]       cfg_index,
	input  logic [tgqg_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  tgqg_pkg::in_item_t                in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output tgqg_pkg::out_item_t               out_data
);
	import tgqg_pkg::*;

	// configuration and derived glyph size
	logic [CFG_W-1:0] inv_w_q, inv_h_q;
	logic [GW_W-1:0]  gw_q;
	logic [GH_W-1:0]  gh_q;
	logic [CFG_W+4:0] gw_sum;
	logic [CFG_W+6:0] gh_sum;

	// pipeline
	logic                 valid_s1, valid_s2, valid_s3;
	in_item_t             item_s1;
	logic                 op_s2, center_s2;
	logic [COLOR_W-1:0]   color_s2;
	logic [CODE_W-1:0]    code_s2;
	logic [PR_W-1:0]      pl_s2, pt_s2, pr_s2, pb_s2;
	logic [NG_W-1:0]      pn_s2;
	logic                 op_s3, center_s3;
	logic [COLOR_W-1:0]   color_s3;
	logic [CODE_W-1:0]    code_s3;
	logic signed [CW-1:0] left_u_s3, top_u_s3, cx_num_s3, cy_num_s3;

	// string state
	logic signed [POS_W-1:0] pen_x_q, pen_y_q, line_start_x_q;
	logic [COLOR_W-1:0]      string_color_q;

	// quad being sent
	logic                    quad_valid_q;
	logic [VCNT_W-1:0]       vert_cnt_q;
	logic signed [POS_W-1:0] qx_l_q, qx_r_q, qy_t_q, qy_b_q;
	logic [TEX_W-1:0]        qu_l_q, qu_r_q;
	logic [COLOR_W-1:0]      qcolor_q;

	// combinational
	logic [PR_W-1:0]         pl_c, pt_c, pr_c, pb_c;
	logic [NG_W-1:0]         pn_c;
	logic [RV_W-1:0]         rl_r, rt_r, rr_r, rb_r;
	logic signed [CW-1:0]    left_u_c, top_u_c, cx_num_c, cy_num_c;
	logic signed [SW-1:0]    bx, by, gw_ext, gh_ext;
	logic signed [POS_W-1:0] begin_x, begin_y, glyph_r, glyph_b;
	logic                    is_newline, is_print, quad_need, quad_free, load_quad;
	logic                    adv_s3, rdy_s3, rdy_s2, rdy_s1, out_last_acc;
	logic [TIDX_W-1:0]       col_l, col_r;

	// configuration writes wait until the item stages are empty
	// the glyph size register follows the new reciprocal in the next cycle
	assign cfg_ready = !valid_s1 && !valid_s2 && !valid_s3;
	assign gw_sum = (CFG_W+5)'(inv_w_q) * (CFG_W+5)'(GW_PX2) + (CFG_W+5)'(RND_HALF);
	assign gh_sum = (CFG_W+7)'(inv_h_q) * (CFG_W+7)'(GH_PX2) + (CFG_W+7)'(RND_HALF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_w_q <= CFG_W'(INV_W_RESET);
			inv_h_q <= CFG_W'(INV_H_RESET);
			gw_q    <= GW_RESET;
			gh_q    <= GH_RESET;
		end else begin
			gw_q <= gw_sum[CFG_W+4:REF_SHIFT];
			gh_q <= gh_sum[CFG_W+6:REF_SHIFT];
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_INV_W: inv_w_q <= cfg_data;
					CFG_INV_H: inv_h_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// handshake chain back from the vertex sequencer
	assign out_last_acc = quad_valid_q && out_ready && (vert_cnt_q == VERT_LAST);
	assign quad_free    = !quad_valid_q || out_last_acc;
	assign adv_s3       = valid_s3 && (!quad_need || quad_free);
	assign rdy_s3       = !valid_s3 || adv_s3;
	assign rdy_s2       = !valid_s2 || rdy_s3;
	assign rdy_s1       = !valid_s1 || rdy_s2;
	assign in_ready     = rdy_s1 && !cfg_valid;
	assign load_quad    = adv_s3 && quad_need;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= in_valid && in_ready;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
		end
	end

	// stage 1: rectangle and centring products
	assign pl_c = (PR_W'(item_s1.rect_left) * PR_W'(inv_w_q)) << 1;
	assign pr_c = (PR_W'(item_s1.rect_right) * PR_W'(inv_w_q)) << 1;
	assign pt_c = (PR_W'(item_s1.rect_top) * PR_W'(inv_h_q)) << 1;
	assign pb_c = (PR_W'(item_s1.rect_bottom) * PR_W'(inv_h_q)) << 1;
	assign pn_c = NG_W'(item_s1.char_count) * NG_W'(gw_q);

	// stage 2: round to ndc and form centring offsets
	always_comb begin
		rl_r     = rnd_px(pl_s2);
		rt_r     = rnd_px(pt_s2);
		rr_r     = rnd_px(pr_s2);
		rb_r     = rnd_px(pb_s2);
		left_u_c = signed'(CW'(rl_r)) - CW'(ONE);
		top_u_c  = CW'(ONE) - signed'(CW'(rt_r));
		cx_num_c = signed'(CW'(rr_r)) - signed'(CW'(rl_r)) - signed'(CW'(pn_s2));
		cy_num_c = signed'(CW'(rb_r)) - signed'(CW'(rt_r)) - signed'(CW'(gh_q));
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) item_s1 <= in_data;
		if (rdy_s2 && valid_s1) begin
			op_s2     <= item_s1.op;
			center_s2 <= item_s1.center_text;
			color_s2  <= item_s1.text_color;
			code_s2   <= item_s1.char_code;
			pl_s2     <= pl_c;
			pt_s2     <= pt_c;
			pr_s2     <= pr_c;
			pb_s2     <= pb_c;
			pn_s2     <= pn_c;
		end
		if (rdy_s3 && valid_s2) begin
			op_s3     <= op_s2;
			center_s3 <= center_s2;
			color_s3  <= color_s2;
			code_s3   <= code_s2;
			left_u_s3 <= left_u_c;
			top_u_s3  <= top_u_c;
			cx_num_s3 <= cx_num_c;
			cy_num_s3 <= cy_num_c;
		end
	end

	// stage 3: pen update and glyph corners
	always_comb begin
		if (center_s3) begin
			bx = SW'(left_u_s3) + SW'(cx_num_s3 >>> 1);
			by = SW'(top_u_s3) - SW'(cy_num_s3 >>> 1);
		end else begin
			bx = SW'(left_u_s3);
			by = SW'(top_u_s3);
		end
		begin_x    = sat_pos(bx);
		begin_y    = sat_pos(by);
		gw_ext     = signed'(SW'(gw_q));
		gh_ext     = signed'(SW'(gh_q));
		glyph_r    = sat_pos(SW'(pen_x_q) + gw_ext);
		glyph_b    = sat_pos(SW'(pen_y_q) - gh_ext);
		is_newline = (code_s3 == CHAR_NEWLINE);
		is_print   = (code_s3 >= CHAR_FIRST) && (code_s3 <= CHAR_LAST);
		quad_need  = valid_s3 && (op_s3 == OP_CHAR) && is_print;
		col_l      = TIDX_W'(code_s3 - CHAR_FIRST);
		col_r      = col_l + TIDX_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q        <= '0;
			pen_y_q        <= '0;
			line_start_x_q <= '0;
			string_color_q <= '0;
		end else if (adv_s3) begin
			if (op_s3 == OP_BEGIN) begin
				pen_x_q        <= begin_x;
				pen_y_q        <= begin_y;
				line_start_x_q <= begin_x;
				string_color_q <= color_s3;
			end else if (is_newline) begin
				pen_x_q <= line_start_x_q;
				pen_y_q <= glyph_b;
			end else if (is_print) begin
				pen_x_q <= glyph_r;
			end
		end
	end

	// vertex sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quad_valid_q <= 1'b0;
			vert_cnt_q   <= '0;
		end else if (load_quad) begin
			quad_valid_q <= 1'b1;
			vert_cnt_q   <= '0;
		end else if (out_last_acc) begin
			quad_valid_q <= 1'b0;
			vert_cnt_q   <= '0;
		end else if (quad_valid_q && out_ready) begin
			vert_cnt_q <= vert_cnt_q + VCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load_quad) begin
			qx_l_q   <= pen_x_q;
			qx_r_q   <= glyph_r;
			qy_t_q   <= pen_y_q;
			qy_b_q   <= glyph_b;
			qu_l_q   <= TEX_TAB[col_l];
			qu_r_q   <= TEX_TAB[col_r];
			qcolor_q <= string_color_q;
		end
	end

	// corner select per vertex
	assign out_valid = quad_valid_q;
	always_comb begin
		out_data.pos_x        = X_RIGHT[vert_cnt_q] ? qx_r_q : qx_l_q;
		out_data.pos_y        = Y_BOTTOM[vert_cnt_q] ? qy_b_q : qy_t_q;
		out_data.tex_u        = X_RIGHT[vert_cnt_q] ? qu_r_q : qu_l_q;
		out_data.tex_v        = Y_BOTTOM[vert_cnt_q];
		out_data.vertex_color = qcolor_q;
		out_data.last_vertex  = (vert_cnt_q == VERT_LAST);
	end

	// checks
	a_quad_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_quad |-> (!quad_valid_q || out_last_acc))
		else $error("quad loaded over a quad still being sent");

	a_stall_only_quad: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !adv_s3) |-> (quad_need && quad_valid_q))
		else $error("stage 3 stalled without a pending quad");

	a_line_start_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s3 && op_s3 == OP_CHAR) |=> $stable(line_start_x_q))
		else $error("line start moved on a character");

	a_last_restart: assert property (@(posedge clk) disable iff (!arst_n)
		out_last_acc |=> (!out_valid || vert_cnt_q == '0))
		else $error("sequencer did not restart after the last vertex");

endmodule

/* test/tb_text_glyph_quad_generator_top.sv */
// testbench for text_glyph_quad_generator_top: directed and random strings with a
// vertex predictor, random idling on both channels and register writes
// depends on tgqg_pkg and rtl/text_glyph_quad_generator_top.sv
`timescale 1ns / 1ps

module tb_text_glyph_quad_generator_top;
	import tgqg_pkg::*;

	localparam int RUN_LIMIT   = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_WAIT  = 8;
	localparam longint POS_HI  = (longint'(1) << (POS_W - 1)) - 1;
	localparam longint POS_LO  = -(longint'(1) << (POS_W - 1));
	// corners of the two triangles: lt, rt, lb, rt, rb, lb
	localparam bit [VERT_N-1:0] RIGHT_CORNER  = 6'b011010;
	localparam bit [VERT_N-1:0] BOTTOM_CORNER = 6'b110100;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	in_item_t          in_data = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	out_item_t         out_data;

	// predictor state
	logic [CFG_W-1:0]         inv_w_m = CFG_W'(INV_W_RESET);
	logic [CFG_W-1:0]         inv_h_m = CFG_W'(INV_H_RESET);
	logic signed [POS_W-1:0]  pen_x_m = '0;
	logic signed [POS_W-1:0]  pen_y_m = '0;
	logic signed [POS_W-1:0]  line_x_m = '0;
	logic [COLOR_W-1:0]       colour_m = '0;

	in_item_t  pending_items[$];
	out_item_t expected_vertices[$];
	int        pushed_count = 0;
	int        taken_count = 0;
	int        cfg_count = 0;
	int        err_count = 0;
	int        cycle_count = 0;
	int        tx_idle = 0;
	int        rx_idle = 0;
	bit        in_taken = 1'b0;
	bit        hold_req = 1'b0;
	bit        hold_done = 1'b0;
	int        hold_left = 0;

	text_glyph_quad_generator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #1 clk = ~clk;

	// q.24 product to position fraction bits, round half up
	function automatic longint round_q24(input longint v);
		return (v + RND_HALF) >>> REF_SHIFT;
	endfunction

	function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
		if (v > POS_HI) begin
			return POS_W'(POS_HI);
		end
		if (v < POS_LO) begin
			return POS_W'(POS_LO);
		end
		return POS_W'(v);
	endfunction

	function automatic logic [TEX_W-1:0] glyph_u(input longint col);
		return TEX_W'((2 * col * TEX_ONE + ATLAS_GLYPHS) / (2 * ATLAS_GLYPHS));
	endfunction

	// pen update and vertex expectations for one accepted transaction
	task automatic predict_glyph_vertices(input in_item_t it);
		longint one, gw, gh, iw, ih, lft, top, rgt, bot;
		logic signed [POS_W-1:0] qr, qb;
		logic [TEX_W-1:0] ul, ur;
		out_item_t v;
		one = ONE;
		iw = longint'(inv_w_m);
		ih = longint'(inv_h_m);
		gw = round_q24(GW_PX2 * iw);
		gh = round_q24(GH_PX2 * ih);
		if (it.op == OP_BEGIN) begin
			lft = round_q24(2 * longint'(it.rect_left) * iw) - one;
			top = one - round_q24(2 * longint'(it.rect_top) * ih);
			if (it.center_text) begin
				rgt = round_q24(2 * longint'(it.rect_right) * iw) - one;
				bot = one - round_q24(2 * longint'(it.rect_bottom) * ih);
				lft += ((rgt - lft) - longint'(it.char_count) * gw) >>> 1;
				top -= ((top - bot) - gh) >>> 1;
			end
			pen_x_m = clamp_pos(lft);
			pen_y_m = clamp_pos(top);
			line_x_m = pen_x_m;
			colour_m = it.text_color;
		end else if (it.char_code == CHAR_NEWLINE) begin
			pen_x_m = line_x_m;
			pen_y_m = clamp_pos(longint'(pen_y_m) - gh);
		end else if (it.char_code >= CHAR_FIRST && it.char_code <= CHAR_LAST) begin
			qr = clamp_pos(longint'(pen_x_m) + gw);
			qb = clamp_pos(longint'(pen_y_m) - gh);
			ul = glyph_u(longint'(it.char_code) - CHAR_FIRST);
			ur = glyph_u(longint'(it.char_code) - CHAR_FIRST + 1);
			for (int k = 0; k < VERT_N; k++) begin
				v.pos_x = RIGHT_CORNER[k] ? qr : pen_x_m;
				v.pos_y = BOTTOM_CORNER[k] ? qb : pen_y_m;
				v.tex_u = RIGHT_CORNER[k] ? ur : ul;
				v.tex_v = BOTTOM_CORNER[k];
				v.vertex_color = colour_m;
				v.last_vertex = (k == VERT_N - 1);
				expected_vertices.push_back(v);
			end
			pen_x_m = qr;
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			err_count++;
		end
	endtask

	// monitor: vertex checks, register shadowing and prediction on input acceptance
	always @(posedge clk) begin
		cycle_count++;
		if (out_valid && out_ready) begin
			if (expected_vertices.size() == 0) begin
				$error("vertex transaction with nothing expected: %p", out_data);
				err_count++;
			end else begin
				out_item_t w;
				w = expected_vertices.pop_front();
				check_field("pos_x", w.pos_x, out_data.pos_x);
				check_field("pos_y", w.pos_y, out_data.pos_y);
				check_field("tex_u", w.tex_u, out_data.tex_u);
				check_field("tex_v", w.tex_v, out_data.tex_v);
				check_field("vertex_color", w.vertex_color, out_data.vertex_color);
				check_field("last_vertex", w.last_vertex, out_data.last_vertex);
			end
		end
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_INV_W: inv_w_m = cfg_data;
				CFG_INV_H: inv_h_m = cfg_data;
				default: ;
			endcase
			cfg_count++;
		end
		in_taken = in_valid && in_ready;
		if (in_taken) begin
			predict_glyph_vertices(in_data);
			taken_count++;
		end
		if (cycle_count >= RUN_LIMIT) begin
			$display("text_glyph_quad_generator_top test failed");
			$finish;
		end
	end

	// sender: next item from the pending queue, with random gaps
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (pending_items.size() != 0 && $urandom_range(0, 99) >= tx_idle) begin
				in_data <= pending_items.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus one long hold-off to back the block up
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rx_idle);
		end
	end

	task automatic push_item(input in_item_t it);
		pending_items.push_back(it);
		pushed_count++;
	endtask

	function automatic in_item_t rand_item();
		in_item_t it;
		it.op = 1'($urandom);
		it.rect_left = PX_W'($urandom);
		it.rect_top = PX_W'($urandom);
		it.rect_right = PX_W'($urandom);
		it.rect_bottom = PX_W'($urandom);
		it.center_text = 1'($urandom);
		it.char_count = ($urandom_range(0, 1)) ? CNT_W'($urandom_range(0, 24))
			: CNT_W'($urandom);
		it.text_color = $urandom;
		it.char_code = CODE_W'($urandom);
		return it;
	endfunction

	task automatic push_begin(input int l, input int t, input int r, input int b,
			input bit ctr, input int n, input logic [COLOR_W-1:0] col);
		in_item_t it;
		it = rand_item();
		it.op = OP_BEGIN;
		it.rect_left = PX_W'(l);
		it.rect_top = PX_W'(t);
		it.rect_right = PX_W'(r);
		it.rect_bottom = PX_W'(b);
		it.center_text = ctr;
		it.char_count = CNT_W'(n);
		it.text_color = col;
		push_item(it);
	endtask

	task automatic push_char(input logic [CODE_W-1:0] code);
		in_item_t it;
		it = rand_item();
		it.op = OP_CHAR;
		it.char_code = code;
		push_item(it);
	endtask

	// mostly well-formed strings: a begin, then printable text with some newlines and junk
	task automatic push_strings(input int n);
		int sent, len, r;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 99) >= 8) begin
				push_begin($urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 4095), $urandom_range(0, 4095), 1'($urandom),
					($urandom_range(0, 1)) ? $urandom_range(0, 24) : $urandom_range(0, 1023),
					$urandom);
				sent++;
			end
			len = $urandom_range(1, 14);
			repeat (len) begin
				r = $urandom_range(0, 99);
				if (r < 76) begin
					push_char(CODE_W'($urandom_range(CHAR_FIRST, CHAR_LAST)));
				end else if (r < 88) begin
					push_char(CHAR_NEWLINE);
				end else begin
					push_char(CODE_W'($urandom));
				end
				sent++;
			end
		end
	endtask

	// all items accepted, all vertices seen, then the pipeline latency
	task automatic wait_drained();
		do @(negedge clk);
		while (taken_count != pushed_count || expected_vertices.size() != 0);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		int target;
		target = cfg_count + 1;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk);
		while (cfg_count != target);
		cfg_valid <= 1'b0;
	endtask

	// test sequence
	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_idle = 21;
		rx_idle = 58;

		// directed: reset pen, field extremes, range ends and skipped codes
		push_char("A");
		push_begin(0, 0, 0, 0, 1'b0, 0, 32'h0000_0000);
		push_char(CHAR_FIRST);
		push_char(CHAR_LAST);
		push_char(CHAR_FIRST - 1);
		push_char(CHAR_LAST + 1);
		push_char(16'h0000);
		push_char(16'hFFFF);
		push_char(CHAR_NEWLINE);
		push_char("M");
		push_begin(4095, 4095, 4095, 4095, 1'b1, 1023, 32'hFFFF_FFFF);
		push_char(CHAR_LAST);
		push_char(CHAR_NEWLINE);
		push_begin(0, 0, 4095, 4095, 1'b1, 0, 32'hA5A5_5A5A);
		push_char("P");
		push_begin(4095, 4095, 0, 0, 1'b1, 1, 32'h5A5A_A5A5);
		push_char("!");
		push_char(CHAR_NEWLINE);
		push_char("~");
		push_begin(100, 200, 900, 700, 1'b0, 5, 32'h1234_5678);
		push_char(CHAR_NEWLINE);
		push_char(CHAR_NEWLINE);
		push_char(CHAR_NEWLINE);
		push_char("Z");
		wait_drained();

		// smallest reciprocals, with one long receiver hold-off
		write_reg(CFG_INV_W, 24'd4096);
		write_reg(CFG_INV_H, 24'd4096);
		@(posedge clk);
		push_strings(75);
		hold_req = 1'b1;
		wait_drained();

		// reciprocals of one half, idling swapped
		write_reg(CFG_INV_W, 24'd8388608);
		write_reg(CFG_INV_H, 24'd8388608);
		@(posedge clk);
		tx_idle = 58;
		rx_idle = 21;
		push_strings(75);
		wait_drained();

		// all-ones height, no idling
		write_reg(CFG_INV_W, CFG_W'($urandom_range(4096, 65536)));
		write_reg(CFG_INV_H, 24'hFF_FFFF);
		@(posedge clk);
		tx_idle = 0;
		rx_idle = 0;
		push_strings(75);
		wait_drained();

		// all-ones width, random height
		write_reg(CFG_INV_W, 24'hFF_FFFF);
		write_reg(CFG_INV_H, CFG_W'($urandom_range(4096, 8388608)));
		@(posedge clk);
		push_strings(75);
		wait_drained();

		if (err_count == 0) begin
			$display("text_glyph_quad_generator_top test passed");
		end else begin
			$display("text_glyph_quad_generator_top test failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/tgqg_pkg.sv
rtl/text_glyph_quad_generator_top.sv
test/tb_text_glyph_quad_generator_top.sv
